>>> hdl/integer_mul_div_unit_core_defines.svh
// Assertion macros for the integer multiply/divide unit.
`ifndef INTEGER_MUL_DIV_UNIT_CORE_DEFINES_SVH
`define INTEGER_MUL_DIV_UNIT_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define IMDU_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define IMDU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hdl/imdu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package imdu_pkg;

   // Default word width of the operands and the result.
   localparam int DATA_WIDTH_DEFAULT = 32;

   // Width of the operation code field.
   localparam int OP_WIDTH = 3;

   // Operation codes.
   typedef enum logic [OP_WIDTH-1:0] {
      OP_MUL  = 3'd0,
      OP_DIVU = 3'd1,
      OP_REMU = 3'd2,
      OP_DIV  = 3'd3,
      OP_REM  = 3'd4
   } op_type;

   // Control carried alongside the data through every stage.
   typedef struct packed {
      op_type op;
      logic   is_div;
      logic   negate;
   } ctl_type;

endpackage

`default_nettype wire

>>> hdl/imdu_prep.sv
`timescale 1ns / 1ps
`default_nettype none

module imdu_prep #(
   parameter int DATA_WIDTH = imdu_pkg::DATA_WIDTH_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          advance,
   input  wire logic                          req_valid,
   input  wire logic [imdu_pkg::OP_WIDTH-1:0] req_op,
   input  wire logic [DATA_WIDTH-1:0]         req_operand_a,
   input  wire logic [DATA_WIDTH-1:0]         req_operand_b,
   output logic                               valid_ff,
   output imdu_pkg::ctl_type                  ctl_ff,
   output logic [DATA_WIDTH-1:0]              rem_ff,
   output logic [DATA_WIDTH-1:0]              num_ff,
   output logic [DATA_WIDTH-1:0]              den_ff
);
   import imdu_pkg::*;

   // Split of each operand into low and high halves for the multiply.
   localparam int LoW = (DATA_WIDTH + 1) / 2;
   localparam int HiW = DATA_WIDTH - LoW;

   op_type                  op;
   logic                    signed_op;
   logic                    a_neg;
   logic                    b_neg;
   logic [DATA_WIDTH-1:0]   mag_a;
   logic [DATA_WIDTH-1:0]   mag_b;
   logic [LoW-1:0]          a_lo;
   logic [LoW-1:0]          b_lo;
   logic [HiW-1:0]          a_hi;
   logic [HiW-1:0]          b_hi;
   logic [2*LoW-1:0]        pp_ll;
   logic [DATA_WIDTH-1:0]   pp_lh;
   logic [DATA_WIDTH-1:0]   pp_hl;
   ctl_type                 ctl_in;
   logic [DATA_WIDTH-1:0]   num_in;
   logic [DATA_WIDTH-1:0]   den_in;

   assign op    = op_type'(req_op);
   assign a_neg = req_operand_a[DATA_WIDTH-1];
   assign b_neg = req_operand_b[DATA_WIDTH-1];

   // Decode the operation
   always_comb begin
      ctl_in    = '0;
      ctl_in.op = op;
      signed_op = 1'b0;
      unique case (op)
         OP_MUL: begin
            ctl_in.is_div = 1'b0;
         end
         OP_DIVU, OP_REMU: begin
            ctl_in.is_div = 1'b1;
         end
         OP_DIV: begin
            ctl_in.is_div = 1'b1;
            ctl_in.negate = a_neg ^ b_neg;
            signed_op     = 1'b1;
         end
         OP_REM: begin
            ctl_in.is_div = 1'b1;
            ctl_in.negate = a_neg;
            signed_op     = 1'b1;
         end
         default: begin
            ctl_in.is_div = 1'b0;
         end
      endcase
   end

   // Magnitudes for the signed divide
   assign mag_a = (signed_op && a_neg) ? ('0 - req_operand_a) : req_operand_a;
   assign mag_b = (signed_op && b_neg) ? ('0 - req_operand_b) : req_operand_b;

   // Partial products of the low product word; cross terms keep only their low half
   assign a_lo  = req_operand_a[LoW-1:0];
   assign b_lo  = req_operand_b[LoW-1:0];
   assign a_hi  = req_operand_a[DATA_WIDTH-1:LoW];
   assign b_hi  = req_operand_b[DATA_WIDTH-1:LoW];
   assign pp_ll = a_lo * b_lo;
   assign pp_lh = a_lo * b_hi;
   assign pp_hl = a_hi * b_lo;

   // Divide: dividend and divisor. Multiply: low product and packed cross terms.
   assign num_in = ctl_in.is_div ? mag_a : pp_ll[DATA_WIDTH-1:0];
   assign den_in = ctl_in.is_div ? mag_b
                                 : DATA_WIDTH'({pp_lh[HiW-1:0], pp_hl[HiW-1:0]});

   // Stage register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         ctl_ff <= ctl_in;
         rem_ff <= '0;
         num_ff <= num_in;
         den_ff <= den_in;
      end
   end

endmodule

`default_nettype wire

>>> hdl/imdu_div_step.sv
`timescale 1ns / 1ps
`default_nettype none

module imdu_div_step #(
   parameter int DATA_WIDTH = imdu_pkg::DATA_WIDTH_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  advance,
   input  wire logic                  in_valid,
   input  imdu_pkg::ctl_type          in_ctl,
   input  wire logic [DATA_WIDTH-1:0] in_rem,
   input  wire logic [DATA_WIDTH-1:0] in_num,
   input  wire logic [DATA_WIDTH-1:0] in_den,
   output logic                       valid_ff,
   output imdu_pkg::ctl_type          ctl_ff,
   output logic [DATA_WIDTH-1:0]      rem_ff,
   output logic [DATA_WIDTH-1:0]      num_ff,
   output logic [DATA_WIDTH-1:0]      den_ff
);
   import imdu_pkg::*;

   logic [DATA_WIDTH-1:0] shifted;
   logic [DATA_WIDTH:0]   trial;
   logic                  take;
   logic [DATA_WIDTH-1:0] rem_in;
   logic [DATA_WIDTH-1:0] num_in;

   // One restoring step: shift in the next dividend bit, try the subtract.
   // The bit shifted out of the remainder sits above the divisor, so the
   // trial runs one bit wider and no borrow means the subtract is kept.
   assign shifted = {in_rem[DATA_WIDTH-2:0], in_num[DATA_WIDTH-1]};
   assign trial   = {in_rem[DATA_WIDTH-1], shifted} - {1'b0, in_den};
   assign take    = ~trial[DATA_WIDTH];

   // Multiply items pass through untouched
   always_comb begin
      rem_in = in_rem;
      num_in = in_num;
      if (in_ctl.is_div) begin
         rem_in = take ? trial[DATA_WIDTH-1:0] : shifted;
         num_in = {in_num[DATA_WIDTH-2:0], take};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         ctl_ff <= in_ctl;
         rem_ff <= rem_in;
         num_ff <= num_in;
         den_ff <= in_den;
      end
   end

endmodule

`default_nettype wire

>>> hdl/imdu_out.sv
`timescale 1ns / 1ps
`default_nettype none

`include "integer_mul_div_unit_core_defines.svh"

module imdu_out #(
   parameter int DATA_WIDTH = imdu_pkg::DATA_WIDTH_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  advance,
   input  wire logic                  fin_valid,
   input  imdu_pkg::ctl_type          fin_ctl,
   input  wire logic [DATA_WIDTH-1:0] fin_rem,
   input  wire logic [DATA_WIDTH-1:0] fin_num,
   input  wire logic [DATA_WIDTH-1:0] fin_den,
   input  wire logic                  rsp_ready,
   output logic                       rsp_valid,
   output logic [DATA_WIDTH-1:0]      rsp_result,
   output logic                       skid_full
);
   import imdu_pkg::*;

   localparam int LoW = (DATA_WIDTH + 1) / 2;
   localparam int HiW = DATA_WIDTH - LoW;

   logic [HiW-1:0]        cross_sum;
   logic [DATA_WIDTH-1:0] product;
   logic [DATA_WIDTH-1:0] div_sel;
   logic [DATA_WIDTH-1:0] result_calc;

   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic [DATA_WIDTH-1:0] rsp_result_ff;
   logic [DATA_WIDTH-1:0] rsp_result_in;
   logic                  skid_valid_ff;
   logic                  skid_valid_in;
   logic [DATA_WIDTH-1:0] skid_result_ff;
   logic [DATA_WIDTH-1:0] skid_result_in;

   // Finish the multiply: add the cross terms into the high part
   assign cross_sum = fin_den[2*HiW-1:HiW] + fin_den[HiW-1:0];
   assign product   = fin_num + {cross_sum, {LoW{1'b0}}};

   // Quotient or remainder, with the sign fix for signed operations
   assign div_sel = (fin_ctl.op == OP_DIV) ? fin_num : fin_rem;

   always_comb begin
      case (fin_ctl.op) inside
         OP_MUL:         result_calc = product;
         OP_DIVU:        result_calc = fin_num;
         OP_REMU:        result_calc = fin_rem;
         OP_DIV, OP_REM: result_calc = fin_ctl.negate ? ('0 - div_sel) : div_sel;
         default:        result_calc = '0;
      endcase
   end

   // Output register with a one-entry skid behind it
   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_result_in  = rsp_result_ff;
      skid_valid_in  = skid_valid_ff;
      skid_result_in = skid_result_ff;
      if (!rsp_valid_ff || rsp_ready) begin
         if (skid_valid_ff) begin
            rsp_valid_in  = 1'b1;
            rsp_result_in = skid_result_ff;
            skid_valid_in = 1'b0;
         end else begin
            rsp_valid_in  = advance && fin_valid;
            rsp_result_in = result_calc;
         end
      end else if (advance && fin_valid) begin
         skid_valid_in  = 1'b1;
         skid_result_in = result_calc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_result_ff  <= rsp_result_in;
      skid_result_ff <= skid_result_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = rsp_result_ff;
   assign skid_full  = skid_valid_ff;

   // Checks on the output and skid ordering
   `IMDU_ASSERT_NOW(a_skid_behind_out, clock, reset, skid_valid_ff, rsp_valid_ff, "skid holds a result while the output is empty")
   `IMDU_ASSERT_NEXT(a_stall_fills_skid, clock, reset, rsp_valid_ff && !rsp_ready && advance && fin_valid, skid_valid_ff, "result arriving at a stalled output was dropped")
   `IMDU_ASSERT_NEXT(a_skid_drains, clock, reset, rsp_valid_ff && rsp_ready && skid_valid_ff, rsp_valid_ff && !skid_valid_ff, "skid did not move to the output after a transfer")

endmodule

`default_nettype wire

>>> hdl/integer_mul_div_unit_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  | Ports                                          | Direction
// ---------+------------------------------------------------+----------
// request  | req_valid, req_ready, req_op, req_operand_a/b  | in
// response | rsp_valid, rsp_ready, rsp_result               | out
//
// One item enters per cycle while req_ready is high; each result passes
// through a prep stage (magnitudes, partial products), DATA_WIDTH
// one-bit restoring divide stages, then the sign fix into the output register.
// Multiply items ride the same stages, so all results leave in order.
// Reset is synchronous and clears the valid bits only.
// A stalled output is backed by a one-entry skid; the pipeline and req_ready
// freeze once the skid is full and restart when the output drains.

module integer_mul_div_unit_core #(
   parameter int DATA_WIDTH = imdu_pkg::DATA_WIDTH_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [imdu_pkg::OP_WIDTH-1:0] req_op,
   input  wire logic [DATA_WIDTH-1:0]         req_operand_a,
   input  wire logic [DATA_WIDTH-1:0]         req_operand_b,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [DATA_WIDTH-1:0]              rsp_result
);
   import imdu_pkg::*;

   logic                  advance;
   logic                  skid_full;

   // Stage outputs: index 0 is the prep stage, index i+1 follows divide step i
   logic                  st_valid [0:DATA_WIDTH];
   ctl_type               st_ctl   [0:DATA_WIDTH];
   logic [DATA_WIDTH-1:0] st_rem   [0:DATA_WIDTH];
   logic [DATA_WIDTH-1:0] st_num   [0:DATA_WIDTH];
   logic [DATA_WIDTH-1:0] st_den   [0:DATA_WIDTH];

   // Whole pipeline moves unless the skid is holding a result
   assign advance   = ~skid_full;
   assign req_ready = advance;

   imdu_prep #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_prep (
      .clock         (clock),
      .reset         (reset),
      .advance       (advance),
      .req_valid     (req_valid),
      .req_op        (req_op),
      .req_operand_a (req_operand_a),
      .req_operand_b (req_operand_b),
      .valid_ff      (st_valid[0]),
      .ctl_ff        (st_ctl[0]),
      .rem_ff        (st_rem[0]),
      .num_ff        (st_num[0]),
      .den_ff        (st_den[0])
   );

   // One quotient bit per stage, most significant first
   for (genvar i = 0; i < DATA_WIDTH; i++) begin : g_step
      imdu_div_step #(
         .DATA_WIDTH (DATA_WIDTH)
      ) u_step (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .in_valid (st_valid[i]),
         .in_ctl   (st_ctl[i]),
         .in_rem   (st_rem[i]),
         .in_num   (st_num[i]),
         .in_den   (st_den[i]),
         .valid_ff (st_valid[i+1]),
         .ctl_ff   (st_ctl[i+1]),
         .rem_ff   (st_rem[i+1]),
         .num_ff   (st_num[i+1]),
         .den_ff   (st_den[i+1])
      );
   end

   imdu_out #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_out (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .fin_valid  (st_valid[DATA_WIDTH]),
      .fin_ctl    (st_ctl[DATA_WIDTH]),
      .fin_rem    (st_rem[DATA_WIDTH]),
      .fin_num    (st_num[DATA_WIDTH]),
      .fin_den    (st_den[DATA_WIDTH]),
      .rsp_ready  (rsp_ready),
      .rsp_valid  (rsp_valid),
      .rsp_result (rsp_result),
      .skid_full  (skid_full)
   );

endmodule

`default_nettype wire

>>> verif/tb.sv
`timescale 1ns / 1ps

module tb;
   import imdu_pkg::*;

   localparam int W = DATA_WIDTH_DEFAULT;
   localparam int RANDOM_ITEMS = 700;
   localparam int DRAIN_CYCLES = 2 * W + 8;
   localparam int CYCLE_LIMIT = 500000;
   localparam int ROW_COUNT = 25;

   // One directed stimulus row; the expected word is only used when fixed_en is set
   typedef struct packed {
      op_type         op;
      logic [W-1:0]   a;
      logic [W-1:0]   b;
      logic           fixed_en;
      logic [W-1:0]   fixed_value;
   } stim_row_type;

   typedef struct {
      int unsigned    item;
      logic [W-1:0]   value;
   } pending_result_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [OP_WIDTH-1:0] req_op = OP_MUL;
   logic [W-1:0]        req_operand_a = '0;
   logic [W-1:0]        req_operand_b = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [W-1:0]        rsp_result;

   // Typed expectation travelling with the current request
   logic                fixed_en = 1'b0;
   logic [W-1:0]        fixed_value = '0;

   pending_result_type  pending_results[$];
   int unsigned         items_in = 0;
   int unsigned         cycle_count = 0;
   int unsigned         mismatches = 0;
   int                  quiet_run = 0;

   stim_row_type directed_rows [ROW_COUNT] = '{
      '{OP_MUL,  32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0000_0000},
      '{OP_MUL,  32'hffff_ffff, 32'hffff_ffff, 1'b1, 32'h0000_0001},
      '{OP_MUL,  32'h8000_0000, 32'h0000_0002, 1'b1, 32'h0000_0000},
      '{OP_MUL,  32'h1234_5678, 32'h9abc_def0, 1'b0, 32'h0000_0000},
      '{OP_DIVU, 32'hffff_ffff, 32'h0000_0001, 1'b1, 32'hffff_ffff},
      '{OP_DIVU, 32'h0000_0007, 32'h0000_0000, 1'b1, 32'hffff_ffff},
      '{OP_DIVU, 32'hffff_ffff, 32'hffff_ffff, 1'b1, 32'h0000_0001},
      '{OP_DIVU, 32'h0000_0100, 32'h0000_0007, 1'b0, 32'h0000_0000},
      '{OP_DIVU, 32'h0000_0000, 32'hffff_ffff, 1'b1, 32'h0000_0000},
      '{OP_REMU, 32'h0000_1234, 32'h0000_0000, 1'b1, 32'h0000_1234},
      '{OP_REMU, 32'hffff_ffff, 32'h0000_0010, 1'b1, 32'h0000_000f},
      '{OP_REMU, 32'h0000_0005, 32'hffff_ffff, 1'b1, 32'h0000_0005},
      '{OP_DIV,  32'h8000_0000, 32'hffff_ffff, 1'b1, 32'h8000_0000},
      '{OP_DIV,  32'h0000_0005, 32'h0000_0000, 1'b1, 32'hffff_ffff},
      '{OP_DIV,  32'h0000_0000, 32'h0000_0000, 1'b1, 32'hffff_ffff},
      '{OP_DIV,  32'hffff_fffb, 32'h0000_0000, 1'b1, 32'h0000_0001},
      '{OP_DIV,  32'hffff_fff9, 32'h0000_0002, 1'b1, 32'hffff_fffd},
      '{OP_DIV,  32'h0000_0007, 32'hffff_fffe, 1'b1, 32'hffff_fffd},
      '{OP_DIV,  32'hffff_fff9, 32'hffff_fffe, 1'b1, 32'h0000_0003},
      '{OP_DIV,  32'h8000_0000, 32'h8000_0000, 1'b1, 32'h0000_0001},
      '{OP_REM,  32'h8000_0000, 32'hffff_ffff, 1'b1, 32'h0000_0000},
      '{OP_REM,  32'hffff_fff9, 32'h0000_0000, 1'b1, 32'hffff_fff9},
      '{OP_REM,  32'hffff_fff9, 32'h0000_0002, 1'b1, 32'hffff_ffff},
      '{OP_REM,  32'h0000_0007, 32'hffff_fffe, 1'b1, 32'h0000_0001},
      '{OP_REM,  32'h7fff_ffff, 32'h8000_0000, 1'b1, 32'h7fff_ffff}
   };

   integer_mul_div_unit_core #(
      .DATA_WIDTH(W)
   ) DUT (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_op        (req_op),
      .req_operand_a (req_operand_a),
      .req_operand_b (req_operand_b),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_result    (rsp_result)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Result word for one request: low product, or quotient/remainder with sign fix-up
   function automatic logic [W-1:0] mul_div_result(op_type op, logic [W-1:0] a,
                                                   logic [W-1:0] b);
      logic [W-1:0] mag_a;
      logic [W-1:0] mag_b;
      logic [W-1:0] word;
      mag_a = a[W-1] ? (~a + 1'b1) : a;
      mag_b = b[W-1] ? (~b + 1'b1) : b;
      case (op)
         OP_MUL: begin
            word = a * b;
         end
         OP_DIVU: begin
            word = (b == '0) ? '1 : a / b;
         end
         OP_REMU: begin
            word = (b == '0) ? a : a % b;
         end
         OP_DIV: begin
            // zero divisor gives an all-ones magnitude, negated for a negative dividend
            word = (mag_b == '0) ? '1 : mag_a / mag_b;
            if (a[W-1] != b[W-1]) word = ~word + 1'b1;
         end
         OP_REM: begin
            word = (mag_b == '0) ? mag_a : mag_a % mag_b;
            if (a[W-1]) word = ~word + 1'b1;
         end
         default: begin
            word = '0;
         end
      endcase
      return word;
   endfunction

   // Operand mix: full random, corners, small values, small negatives, shifted values
   function automatic logic [W-1:0] random_operand();
      logic [W-1:0] corners [5] = '{32'h0, 32'h1, 32'hffff_ffff, 32'h8000_0000,
                                    32'h7fff_ffff};
      logic [W-1:0] word;
      case ($urandom_range(0, 9))
         4: word = corners[$urandom_range(0, 4)];
         5: word = $urandom_range(0, 15);
         6: word = -$urandom_range(1, 15);
         7: word = $urandom >> $urandom_range(0, W - 1);
         8: word = $urandom << $urandom_range(0, W - 1);
         default: word = $urandom;
      endcase
      return word;
   endfunction

   // Idle cycles before the next request; occasional runs with no gaps at all
   function automatic int request_gap();
      int pick;
      if (quiet_run > 0) begin
         quiet_run--;
         return 0;
      end
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
         quiet_run = $urandom_range(20, 60);
         return 0;
      end
      if (pick < 55) return 0;
      if (pick < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Present one request and hold it until the transfer
   task automatic send_request(op_type op, logic [W-1:0] a, logic [W-1:0] b,
                               logic want_fixed, logic [W-1:0] fixed_word);
      int gap;
      gap = request_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_op        <= op;
      req_operand_a <= a;
      req_operand_b <= b;
      fixed_en      <= want_fixed;
      fixed_value   <= fixed_word;
      do @(posedge clock); while (!req_ready);
   endtask

   // Stimulus: reset, directed rows, random requests, then drain
   initial begin
      int i;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      for (i = 0; i < ROW_COUNT; i++) begin
         send_request(directed_rows[i].op, directed_rows[i].a, directed_rows[i].b,
                      directed_rows[i].fixed_en, directed_rows[i].fixed_value);
      end

      for (i = 0; i < RANDOM_ITEMS; i++) begin
         // halfway through, hold off until the pipeline has fully emptied
         if (i == RANDOM_ITEMS / 2) begin
            req_valid <= 1'b0;
            @(posedge clock);
            while (pending_results.size() != 0) @(posedge clock);
         end
         send_request(op_type'($urandom_range(0, 4)), random_operand(), random_operand(),
                      1'b0, '0);
      end
      req_valid <= 1'b0;

      // let the last transfer reach the queue before it is polled
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && pending_results.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // Result-side back-pressure: mostly short stalls, a few long, occasional long ready stretches
   initial begin
      int on_span;
      int off_span;
      forever begin
         on_span = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200)
                                              : $urandom_range(1, 12);
         rsp_ready <= 1'b1;
         repeat (on_span) @(posedge clock);
         off_span = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                               : $urandom_range(1, 4);
         rsp_ready <= 1'b0;
         repeat (off_span) @(posedge clock);
      end
   end

   // Record each request transfer, check each result transfer, watch the cycle limit
   always @(posedge clock) begin
      pending_result_type oldest;
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else if (!reset) begin
         if (req_valid && req_ready) begin
            oldest.item  = items_in;
            oldest.value = fixed_en ? fixed_value
                                    : mul_div_result(op_type'(req_op), req_operand_a,
                                                     req_operand_b);
            pending_results.push_back(oldest);
            items_in++;
         end
         if (rsp_valid && rsp_ready) begin
            if (pending_results.size() == 0) begin
               mismatches++;
               $display("%0t: result %h with no request outstanding, expected none",
                        $time, rsp_result);
            end else begin
               oldest = pending_results.pop_front();
               if (rsp_result !== oldest.value) begin
                  mismatches++;
                  $display("%0t: item %0d result mismatch, expected %h, actual %h",
                           $time, oldest.item, oldest.value, rsp_result);
               end
            end
         end
      end
   end

endmodule

>>> sim.f
+incdir+hdl
hdl/imdu_pkg.sv
hdl/imdu_prep.sv
hdl/imdu_div_step.sv
hdl/imdu_out.sv
hdl/integer_mul_div_unit_core.sv
verif/tb.sv
